/* hw/rtl/flr_pkg.sv */
// Shared types, codes and constants for the false-position log root unit.
// Used by flr_mul, flr_div, the top level and the checker; depends on nothing.
package flr_pkg;

  localparam int VAL_W = 31;
  localparam int F_W   = 32;
  localparam int NUM_W = 62;
  localparam int DEN_W = 33;
  localparam int MAG_W = 35;
  localparam int MUL_W = 32;
  localparam int CAP_W = 6;
  localparam int CNT_W = 7;
  localparam logic [MUL_W-1:0] LN2_Q28 = 32'd186065279;
  localparam logic [VAL_W-1:0] TOL_RESET = 31'd328;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd10;

  typedef enum logic [1:0] {
    ST_CONV   = 2'd0,
    ST_NOROOT = 2'd1,
    ST_CAP    = 2'd2
  } status_t;

  typedef enum logic {
    REG_TOL = 1'b0,
    REG_CAP = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C
  } ln_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_NORM, S_IDX, S_TAB, S_INT, S_L2, S_M0, S_M1, S_FIN, S_RND,
    S_ROUTE, S_SM0, S_SM1, S_SNUM, S_SABS, S_SDIV, S_EVAL
  } state_t;

  // One entry of the log2(1 + i/depth) table in Q30, by repeated squaring.
  function automatic logic [VAL_W-1:0] lg_entry(input logic [63:0] z0);
    logic [63:0] z;
    logic [VAL_W-1:0] res;
    z = z0;
    res = '0;
    for (int k = 1; k <= 30; k++) begin
      z = (z * z) >> 30;
      if (z >= (64'd1 << 31)) begin
        z = z >> 1;
        res = res | (31'd1 << (30 - k));
      end
    end
    return res;
  endfunction

endpackage

/* hw/rtl/flr_mul.sv */
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on flr_pkg for the operand width.
module flr_mul (
  input  logic                          clk,
  input  logic [flr_pkg::MUL_W-1:0]     op_a,
  input  logic [flr_pkg::MUL_W-1:0]     op_b,
  output logic [2*flr_pkg::MUL_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* hw/rtl/flr_div.sv */
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Depends on flr_pkg for the dividend and divisor widths.
module flr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [flr_pkg::NUM_W-1:0]   dividend,
  input  logic [flr_pkg::DEN_W-1:0]   divisor,
  output logic [flr_pkg::NUM_W-1:0]   quotient,
  output logic                        done
);

  localparam int CW = $clog2(flr_pkg::NUM_W + 1);

  logic [flr_pkg::DEN_W-1:0] rem;
  logic [CW-1:0]             cnt;
  logic                      running;
  logic [flr_pkg::DEN_W:0]   trial;

  assign trial = {rem, quotient[flr_pkg::NUM_W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(flr_pkg::NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      if (!trial[flr_pkg::DEN_W]) begin
        rem <= trial[flr_pkg::DEN_W-1:0];
      end else begin
        rem <= {rem[flr_pkg::DEN_W-2:0], quotient[flr_pkg::NUM_W-1]};
      end
      quotient <= {quotient[flr_pkg::NUM_W-2:0], ~trial[flr_pkg::DEN_W]};
    end
  end

endmodule

/* hw/rtl/false_position_log_root_unit.sv */
// Top level of the false-position root finder for ln over an unsigned interval.
// Depends on flr_pkg, flr_mul (shared multiplier) and flr_div (serial divider).
//
//  channel   | ports                                 | handshake
//  ----------+---------------------------------------+-------------------------------
//  command   | lower_end, upper_end                  | beat taken when start && !busy
//  result    | root, status, refinements             | beat shown for one cycle on done
//  config    | cfg_index, cfg_data                   | written when cfg_we is high
//
// One command beat is processed while busy stays high. Each logarithm
// normalizes its argument one leading zero at a time, then runs the table
// lookup, interpolation and ln2 scaling; each secant estimate with its loop
// test waits on the serial divider. A command costs one check state, 2 ln and a
// secant up front, and then one ln and a secant per refinement.
// Reset (rst, synchronous) returns the sequencer to idle and restores the
// tolerance to 328 and the iteration cap to 10. The receiver cannot stall:
// the result beat is held in output registers and shown on done for one cycle.
module false_position_log_root_unit #(
  parameter int FRAC_BITS       = 16,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [30:0]                 lower_end,
  input  logic [30:0]                 upper_end,
  output logic [30:0]                 root,
  output logic [1:0]                  status,
  output logic [6:0]                  refinements,
  output logic                        done,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [30:0]                 cfg_data
);

  localparam int IDX_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int SH    = 30 - FRAC_BITS;
  localparam logic [35:0] RND_ADD = 36'd1 << (29 - FRAC_BITS);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LOG_TABLE_DEPTH - 1);

  // log2(1 + i/depth) in Q30; the last entry is exactly one.
  logic [30:0] lg_tab [0:LOG_TABLE_DEPTH];
  for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [63:0] Z0 =
      ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / LOG_TABLE_DEPTH;
    localparam logic [30:0] ENT =
      (gi == LOG_TABLE_DEPTH) ? 31'h4000_0000 : flr_pkg::lg_entry(Z0);
    assign lg_tab[gi] = ENT;
  end

  flr_pkg::state_t  state, state_next;
  flr_pkg::ln_sel_t sel;

  // Configuration registers.
  logic [30:0] tolerance;
  logic [5:0]  iteration_cap;

  // Working registers of the iteration.
  logic [30:0]        a, b, c, x;
  logic [4:0]         p;
  logic [29:0]        r;
  logic [30:0]        t0, t1;
  logic [34:0]        mag;
  logic               neg;
  logic [63:0]        acc;
  logic [35:0]        mag1;
  logic signed [31:0] fa, fb, fn;
  logic signed [63:0] n1, num;
  logic signed [32:0] den;
  logic               qneg;
  logic [6:0]         iter;

  // Shared multiplier and divider.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start, div_done;
  logic [61:0] quot;
  logic [61:0] num_abs;
  logic [32:0] den_abs;

  flr_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  flr_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(num_abs), .divisor(den_abs),
    .quotient(quot), .done(div_done)
  );

  // Helper values of the table step, the log2 assembly and the loop test.
  logic [IDX_W-1:0] idx_raw, idx;
  logic [30:0]      lm;
  logic             p_ge;
  logic [5:0]       whole;
  logic [35:0]      l2w;
  logic [35:0]      fm;
  logic [31:0]      fa_abs, fb_abs;
  logic             fn_pos;
  logic             fa_pos;
  logic [30:0]      err;
  logic [30:0]      c_clamp;

  always_comb begin
    idx_raw = prod[30 +: IDX_W];
    idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
    lm      = t0 + prod[60:30];
    p_ge    = {1'b0, p} >= 6'(FRAC_BITS);
    whole   = p_ge ? ({1'b0, p} - 6'(FRAC_BITS)) : (6'(FRAC_BITS) - {1'b0, p});
    l2w     = p_ge ? ({whole, 30'd0} + 36'(lm)) : ({whole, 30'd0} - 36'(lm));
    fm      = (mag1 + RND_ADD) >> SH;
    fa_abs  = fa[31] ? 32'(-fa) : 32'(fa);
    fb_abs  = fb[31] ? 32'(-fb) : 32'(fb);
    fn_pos  = !fn[31] && (fn != 32'sd0);
    fa_pos  = !fa[31] && (fa != 32'sd0);
    err     = (a > b) ? (a - b) : (b - a);
    num_abs = num[63] ? 62'(-num) : num[61:0];
    den_abs = den[32] ? 33'(-den) : 33'(den);
    // Truncated quotient, clamped to 1 .. 2^31-1; a zero divisor keeps a.
    if (den == 33'sd0) begin
      c_clamp = a;
    end else if (qneg || quot == 62'd0) begin
      c_clamp = 31'd1;
    end else if (quot[61:31] != '0) begin
      c_clamp = '1;
    end else begin
      c_clamp = quot[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, multiplier operands and the divider launch.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      flr_pkg::S_IDLE:  if (start) state_next = flr_pkg::S_CHECK;
      flr_pkg::S_CHECK: begin
        state_next = (a == '0 || b == '0) ? flr_pkg::S_IDLE : flr_pkg::S_NORM;
      end
      flr_pkg::S_NORM:  if (x[30]) state_next = flr_pkg::S_IDX;
      flr_pkg::S_IDX: begin
        mul_a      = {2'b00, x[29:0]};
        mul_b      = 32'(LOG_TABLE_DEPTH);
        state_next = flr_pkg::S_TAB;
      end
      flr_pkg::S_TAB:   state_next = flr_pkg::S_INT;
      flr_pkg::S_INT: begin
        mul_a      = 32'(t1 - t0);
        mul_b      = {2'b00, r};
        state_next = flr_pkg::S_L2;
      end
      flr_pkg::S_L2:    state_next = flr_pkg::S_M0;
      flr_pkg::S_M0: begin
        mul_a      = mag[31:0];
        mul_b      = flr_pkg::LN2_Q28;
        state_next = flr_pkg::S_M1;
      end
      flr_pkg::S_M1: begin
        mul_a      = {29'd0, mag[34:32]};
        mul_b      = flr_pkg::LN2_Q28;
        state_next = flr_pkg::S_FIN;
      end
      flr_pkg::S_FIN:   state_next = flr_pkg::S_RND;
      flr_pkg::S_RND:   state_next = flr_pkg::S_ROUTE;
      flr_pkg::S_ROUTE: begin
        unique case (sel)
          flr_pkg::SEL_A: state_next = flr_pkg::S_NORM;
          flr_pkg::SEL_B: begin
            if (fa == 32'sd0 || fn == 32'sd0 || (fa[31] == fn[31])) begin
              state_next = flr_pkg::S_IDLE;
            end else begin
              state_next = flr_pkg::S_SM0;
            end
          end
          default: state_next = flr_pkg::S_SM0;
        endcase
      end
      flr_pkg::S_SM0: begin
        mul_a      = fb_abs;
        mul_b      = {1'b0, a};
        state_next = flr_pkg::S_SM1;
      end
      flr_pkg::S_SM1: begin
        mul_a      = fa_abs;
        mul_b      = {1'b0, b};
        state_next = flr_pkg::S_SNUM;
      end
      flr_pkg::S_SNUM:  state_next = flr_pkg::S_SABS;
      flr_pkg::S_SABS: begin
        div_start  = 1'b1;
        state_next = flr_pkg::S_SDIV;
      end
      flr_pkg::S_SDIV:  if (div_done) state_next = flr_pkg::S_EVAL;
      flr_pkg::S_EVAL: begin
        if (err <= tolerance || iter > {1'b0, iteration_cap}) begin
          state_next = flr_pkg::S_IDLE;
        end else begin
          state_next = flr_pkg::S_NORM;
        end
      end
      default: state_next = flr_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != flr_pkg::S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance     <= flr_pkg::TOL_RESET;
      iteration_cap <= flr_pkg::CAP_RESET;
    end else if (cfg_we) begin
      unique case (flr_pkg::reg_idx_t'(cfg_index))
        flr_pkg::REG_TOL: tolerance     <= cfg_data;
        flr_pkg::REG_CAP: iteration_cap <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && (state_next == flr_pkg::S_IDLE);
    end
  end

  // Datapath, stepped by the sequencer state.
  always_ff @(posedge clk) begin
    case (state)
      flr_pkg::S_IDLE: begin
        a    <= lower_end;
        b    <= upper_end;
        iter <= '0;
      end
      flr_pkg::S_CHECK: begin
        x   <= a;
        p   <= 5'd30;
        sel <= flr_pkg::SEL_A;
        if (a == '0 || b == '0) begin
          root        <= '0;
          status      <= flr_pkg::ST_NOROOT;
          refinements <= '0;
        end
      end
      flr_pkg::S_NORM: begin
        if (!x[30]) begin
          x <= {x[29:0], 1'b0};
          p <= p - 1'b1;
        end
      end
      flr_pkg::S_TAB: begin
        r  <= prod[29:0];
        t0 <= lg_tab[idx];
        t1 <= lg_tab[idx + 1'b1];
      end
      flr_pkg::S_L2: begin
        mag <= l2w[34:0];
        neg <= !p_ge && (l2w != '0);
      end
      flr_pkg::S_M1:  acc  <= prod;
      flr_pkg::S_FIN: mag1 <= 36'((acc + {prod[31:0], 32'd0} + 64'd134217728) >> 28);
      flr_pkg::S_RND: fn   <= neg ? -$signed(32'(fm)) : $signed(32'(fm));
      flr_pkg::S_ROUTE: begin
        unique case (sel)
          flr_pkg::SEL_A: begin
            fa  <= fn;
            x   <= b;
            p   <= 5'd30;
            sel <= flr_pkg::SEL_B;
          end
          flr_pkg::SEL_B: begin
            fb          <= fn;
            root        <= '0;
            status      <= flr_pkg::ST_NOROOT;
            refinements <= '0;
          end
          default: begin
            // Replace the end whose ln has the sign of ln(c).
            if ((fa[31] && fn_pos) || (fa_pos && fn[31])) begin
              b  <= c;
              fb <= fn;
            end else begin
              a  <= c;
              fa <= fn;
            end
          end
        endcase
      end
      flr_pkg::S_SM1:  n1 <= fb[31] ? -$signed(prod) : $signed(prod);
      flr_pkg::S_SNUM: begin
        num <= fa[31] ? (n1 + $signed(prod)) : (n1 - $signed(prod));
        den <= 33'(fb) - 33'(fa);
      end
      flr_pkg::S_SABS: qneg <= num[63] ^ den[32];
      flr_pkg::S_SDIV: if (div_done) c <= c_clamp;
      flr_pkg::S_EVAL: begin
        root        <= c;
        refinements <= iter;
        status      <= (err > tolerance) ? flr_pkg::ST_CAP : flr_pkg::ST_CONV;
        iter        <= iter + 1'b1;
        x           <= c;
        p           <= 5'd30;
        sel         <= flr_pkg::SEL_C;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/flr_check.sv */
// Port-level checker for the false-position log root unit, bound to the top.
// Depends on flr_pkg for the status codes.
module flr_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [30:0] root,
  input logic [1:0]  status,
  input logic [6:0]  refinements
);

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command beat taken but unit not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("result beat while busy or back to back");

  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == flr_pkg::ST_CONV || status == flr_pkg::ST_NOROOT ||
              status == flr_pkg::ST_CAP))
    else $error("undefined status code");

  a_noroot_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == flr_pkg::ST_NOROOT |-> root == '0 && refinements == '0)
    else $error("no-root result carries data");

  a_root_pos: assert property (@(posedge clk) disable iff (rst)
    done && status != flr_pkg::ST_NOROOT |-> root != '0 && refinements <= 7'd64)
    else $error("estimate out of range");

endmodule

bind false_position_log_root_unit flr_check u_flr_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .root(root), .status(status), .refinements(refinements)
);

/* dv/false_position_log_root_unit_test.sv */
// Self-checking bench for the false-position ln root finder: random and directed
// intervals are driven on the command port and every result beat is compared
// with a behavioral predictor kept in this file. Depends on flr_pkg.
module false_position_log_root_unit_test;

  localparam int FRAC = 16;
  localparam int DEPTH = 64;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [30:0] lower_end = '0;
  logic [30:0] upper_end = '0;
  logic [30:0] root;
  logic [1:0] status;
  logic [6:0] refinements;
  logic done;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  // One predicted result beat.
  typedef struct packed {
    logic [30:0] root;
    flr_pkg::status_t status;
    logic [6:0] refinements;
  } root_beat_t;

  root_beat_t pending_roots[$];
  int mismatches = 0;
  longint cycles = 0;
  int send_idle_pct = 0;

  // Predictor copies of the two registers and of the log2 mantissa table.
  logic [30:0] tol_shadow;
  logic [5:0] cap_shadow;
  logic [31:0] log2_tab[DEPTH+1];

  always #5 clk = ~clk;

  false_position_log_root_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lower_end(lower_end), .upper_end(upper_end),
    .root(root), .status(status), .refinements(refinements), .done(done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Build the log2(1 + i/DEPTH) table with the same square-and-compare method
  // the block uses, written out here independently.
  task automatic build_log2_table();
    logic [63:0] z;
    logic [31:0] bits;
    for (int i = 0; i <= DEPTH; i++) begin
      z = ((64'(DEPTH + i)) << 30) / DEPTH;
      bits = '0;
      for (int k = 1; k <= 30; k++) begin
        z = (z * z) >> 30;
        if (z >= (64'd1 << 31)) begin
          z = z >> 1;
          bits |= 32'd1 << (30 - k);
        end
      end
      log2_tab[i] = (i == DEPTH) ? 32'h4000_0000 : bits;
    end
  endtask

  // Natural log in signed Q16.16: leading-one position plus interpolated
  // mantissa log2, scaled by ln2 with the two roundings the block applies.
  function automatic longint natural_log(logic [30:0] x);
    int p;
    logic [63:0] m, pr, idx, r, t0, t1, lm, mag;
    longint l2;
    logic neg;
    if (x == 0) x = 31'd1;
    p = 30;
    while (p > 0 && !x[p]) p--;
    m = ((64'(x)) << (30 - p)) & 64'h3FFF_FFFF;
    pr = m * DEPTH;
    idx = pr >> 30;
    r = pr & 64'h3FFF_FFFF;
    if (idx >= DEPTH) idx = DEPTH - 1;
    t0 = log2_tab[idx];
    t1 = log2_tab[idx + 1];
    lm = t0 + (((t1 - t0) * r) >> 30);
    l2 = (longint'(p) - FRAC) * (64'sd1 <<< 30) + longint'(lm);
    neg = l2 < 0;
    mag = neg ? 64'(-l2) : 64'(l2);
    mag = (mag * 64'(flr_pkg::LN2_Q28) + (64'd1 << 27)) >> 28;
    mag = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Secant estimate, truncated toward zero and clamped to 1 .. 2^31-1.
  function automatic logic [30:0] secant_point(logic [30:0] a, logic [30:0] b,
                                               longint fa, longint fb);
    longint num, den, q;
    num = fb * longint'(a) - fa * longint'(b);
    den = fb - fa;
    if (den == 0) return a;
    q = num / den;
    if (q < 1) q = 1;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[30:0];
  endfunction

  function automatic root_beat_t predict_root(logic [30:0] a, logic [30:0] b);
    root_beat_t res;
    longint fa, fb, fc;
    logic [30:0] c, width;
    int n;
    res = '{root: '0, status: flr_pkg::ST_NOROOT, refinements: '0};
    if (a == 0 || b == 0) return res;
    fa = natural_log(a);
    fb = natural_log(b);
    if (fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) return res;
    c = secant_point(a, b, fa, fb);
    width = a > b ? a - b : b - a;
    n = 0;
    while (width > tol_shadow) begin
      n++;
      fc = natural_log(c);
      if ((fa < 0 && fc > 0) || (fa > 0 && fc < 0)) begin
        b = c;
        fb = fc;
      end else begin
        a = c;
        fa = fc;
      end
      c = secant_point(a, b, fa, fb);
      width = a > b ? a - b : b - a;
      if (n > cap_shadow) break;
    end
    res.root = c;
    res.status = width > tol_shadow ? flr_pkg::ST_CAP : flr_pkg::ST_CONV;
    res.refinements = n[6:0];
    return res;
  endfunction

  // Result checker: each done beat is matched against the oldest prediction.
  always @(posedge clk) begin
    root_beat_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: root=%0d status=%0d refinements=%0d",
                   root, status, refinements);
      end else begin
        want = pending_roots.pop_front();
        if (root !== want.root || status !== want.status ||
            refinements !== want.refinements) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected root=%0d status=%0d ref=%0d, got %0d %0d %0d",
                     want.root, want.status, want.refinements, root, status, refinements);
        end
      end
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one command beat; the prediction is queued at the accepting edge.
  // Start stays high after the beat so that the next call can follow
  // directly; a gap or a drain lowers it while the block is still busy.
  task automatic send_interval(logic [30:0] a, logic [30:0] b);
    bit idle_now;
    idle_now = send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct;
    if (idle_now) start <= 1'b0;
    while (idle_now) begin
      @(negedge clk);
      idle_now = $urandom_range(99, 0) < send_idle_pct;
    end
    lower_end <= a;
    upper_end <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_roots.push_back(predict_root(a, b));
    @(negedge clk);
  endtask

  // Wait until every expected beat is in, then a guard stretch for latency.
  task automatic drain();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(flr_pkg::reg_idx_t idx, logic [30:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == flr_pkg::REG_TOL) tol_shadow = value;
    else cap_shadow = value[5:0];
  endtask

  // Mostly intervals that straddle 1.0 (ln changes sign), mixed with noise.
  function automatic logic [30:0] below_one();
    return 31'($urandom_range(32'hFFFF, 1));
  endfunction

  function automatic logic [30:0] above_one();
    case ($urandom_range(2, 0))
      0: return 31'($urandom_range(32'h2_0000, 32'h1_0001));
      1: return 31'($urandom_range(32'h100_0000, 32'h1_0001));
      default: return 31'($urandom_range(32'h7FFF_FFFF, 32'h1_0001));
    endcase
  endfunction

  task automatic send_random(int count);
    logic [30:0] a, b, t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) < 8) begin
        a = below_one();
        b = above_one();
        if ($urandom_range(1, 0)) begin
          t = a; a = b; b = t;
        end
      end else begin
        a = 31'($urandom);
        b = 31'($urandom);
      end
      send_interval(a, b);
    end
  endtask

  // Field extremes and every special case: zero ends, an end exactly at one,
  // same-sign ends, reversed ends, and the widest straddling interval.
  task automatic test_directed();
    send_interval(31'd0, 31'h2_0000);
    send_interval(31'h8000, 31'd0);
    send_interval(31'd0, 31'd0);
    send_interval(31'h1_0000, 31'h3_0000);
    send_interval(31'h8000, 31'h1_0000);
    send_interval(31'h2_0000, 31'h4_0000);
    send_interval(31'h100, 31'h8000);
    send_interval(31'd1, 31'h7FFF_FFFF);
    send_interval(31'h7FFF_FFFF, 31'd1);
    send_interval(31'h8000, 31'h2_0000);
    send_interval(31'h2_0000, 31'h8000);
    send_interval(31'hFFFF, 31'h1_0001);
    send_interval(31'h7FFF_FFFF, 31'h7FFF_FFFE);
    send_interval(31'd1, 31'd2);
    send_interval(31'h5555, 31'h2AAA_AAAA);
    send_interval(31'h2AAA, 31'h5555_5555);
  endtask

  task automatic test_config_sweep();
    write_reg(flr_pkg::REG_TOL, 31'd0);
    write_reg(flr_pkg::REG_CAP, 31'd63);
    send_random(30);
    write_reg(flr_pkg::REG_CAP, 31'd0);
    send_random(30);
    write_reg(flr_pkg::REG_TOL, 31'h7FFF_FFFF);
    send_random(20);
    write_reg(flr_pkg::REG_TOL, 31'd65536);
    write_reg(flr_pkg::REG_CAP, 31'd3);
    send_random(30);
    write_reg(flr_pkg::REG_TOL, 31'd1);
    write_reg(flr_pkg::REG_CAP, 31'd20);
    send_random(30);
  endtask

  // Sender gap phases; the receiver has no stall input to exercise.
  task automatic test_idle_phases();
    write_reg(flr_pkg::REG_TOL, 31'd328);
    write_reg(flr_pkg::REG_CAP, 31'd10);
    send_idle_pct = 0;
    send_random(100);
    send_idle_pct = 75;
    send_random(100);
    send_idle_pct = 29;
    send_random(80);
    send_idle_pct = 0;
    write_reg(flr_pkg::REG_TOL, 31'($urandom));
    write_reg(flr_pkg::REG_CAP, 31'($urandom_range(63, 0)));
    send_random(90);
  endtask

  initial begin
    build_log2_table();
    tol_shadow = flr_pkg::TOL_RESET;
    cap_shadow = flr_pkg::CAP_RESET;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_idle_phases();
    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/flr_pkg.sv
hw/rtl/flr_mul.sv
hw/rtl/flr_div.sv
hw/rtl/false_position_log_root_unit.sv
hw/rtl/flr_check.sv
dv/false_position_log_root_unit_test.sv
